// File: hw/rtl/assert_macros.svh
// assertion macros for the rtl, used by smf_byte_stream_parser.sv
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked on the same edge
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/smf_pkg.sv
// package for the midi file parser: phases, result kinds, error codes
// no dependencies
package smf_pkg;

  localparam int MaxVarlenBytes = 4;

  typedef enum logic [3:0] {
    PH_HDR_TAG, PH_HDR_LEN, PH_HDR_FMT, PH_HDR_NTRK, PH_HDR_DIV,
    PH_TRK_TAG, PH_TRK_LEN, PH_DELTA, PH_STATUS, PH_DATA1, PH_DATA2,
    PH_META_TYPE, PH_VLEN, PH_PAYLOAD, PH_DONE, PH_ERROR
  } phase_t;

  localparam logic [2:0] KIND_HEADER  = 3'd0;
  localparam logic [2:0] KIND_TRACK   = 3'd1;
  localparam logic [2:0] KIND_CHANNEL = 3'd2;
  localparam logic [2:0] KIND_META    = 3'd3;
  localparam logic [2:0] KIND_SYSEX   = 3'd4;
  localparam logic [2:0] KIND_PAYLOAD = 3'd5;
  localparam logic [2:0] KIND_ERROR   = 3'd6;

  localparam logic [2:0] ERR_MTHD     = 3'd0;
  localparam logic [2:0] ERR_HDR_LEN  = 3'd1;
  localparam logic [2:0] ERR_FORMAT   = 3'd2;
  localparam logic [2:0] ERR_MTRK     = 3'd3;
  localparam logic [2:0] ERR_STATUS   = 3'd4;
  localparam logic [2:0] ERR_TRAILING = 3'd5;

  localparam logic [31:0] TagHdr = 32'h4D546864;
  localparam logic [31:0] TagTrk = 32'h4D54726B;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       file_start;
  } smf_in_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [27:0] delta_ticks;
    logic [7:0]  status_byte;
    logic [7:0]  meta_type;
    logic [27:0] payload_length;
    logic [7:0]  first_data;
    logic [7:0]  second_data;
    logic [1:0]  file_format;
    logic [15:0] track_count;
    logic [15:0] division_word;
    logic [2:0]  error_code;
  } smf_out_t;

  // tag byte at position idx, most significant first
  function automatic logic [7:0] tag_byte(input logic [31:0] tag, input logic [1:0] idx);
    tag_byte = tag[8*(3-idx) +: 8];
  endfunction

endpackage

// File: hw/rtl/smf_if.sv
// valid/ready channel carrying one request of a given payload type
// depends on smf_pkg for payload types
interface smf_in_if (input logic clk);
  logic             valid;
  logic             ready;
  smf_pkg::smf_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface smf_out_if (input logic clk);
  logic              valid;
  logic              ready;
  smf_pkg::smf_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/smf_byte_stream_parser.sv
// midi file byte parser top level: one byte per request, zero or one result
// depends on smf_pkg, smf_if.sv and assert_macros.svh
//
// usage:
//   in channel carries one file byte plus file_start; file_start restarts
//   the parser on that byte. out channel carries one event record.
//   each byte is parsed in the cycle it is accepted; its result (if any)
//   lands in the output register and is visible the next cycle, and one
//   byte is taken per cycle while the output register is not stalled.
//   the parse state update for a byte is a single combinational pass.
//   in_ready is high whenever the output register is empty or being taken
//   this cycle; a stalled receiver holds the result and in_ready drops.
//   after reset the parser expects the MThd tag and holds no result.
//   after an error no results come until a byte with file_start.
//   bytes that cause no result are consumed without output.
`include "assert_macros.svh"

module smf_byte_stream_parser #(
  parameter int MAX_VARLEN_BYTES = smf_pkg::MaxVarlenBytes
) (
  input  logic clk,
  input  logic rst_n,
  smf_in_if.sink    in_ch,
  smf_out_if.source out_ch
);

  smf_pkg::phase_t ph_r, ph_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [7:0]  rs_r, rs_nxt;
  logic [27:0] hdelta_r, hdelta_nxt;
  logic [7:0]  hstat_r, hstat_nxt;
  logic [7:0]  hmeta_r, hmeta_nxt;
  logic [7:0]  hd1_r, hd1_nxt;
  logic [27:0] pleft_r, pleft_nxt;
  logic [31:0] cleft_r, cleft_nxt;
  logic [15:0] tleft_r, tleft_nxt;
  logic [1:0]  hfmt_r, hfmt_nxt;
  logic [15:0] htrk_r, htrk_nxt;

  logic              ovalid_r, ovalid_nxt;
  smf_pkg::smf_out_t odata_r, res;
  logic              res_v;
  logic              accept;

  assign in_ch.ready  = !ovalid_r || out_ch.ready;
  assign accept       = in_ch.valid && in_ch.ready;
  assign out_ch.valid = ovalid_r;
  assign out_ch.data  = odata_r;

  // parse one byte
  always_comb begin
    smf_pkg::phase_t ph;
    logic [2:0]  cnt, cnt1;
    logic [31:0] acc, fx, vl;
    logic [27:0] pl;
    logic [31:0] cl;
    logic [15:0] tl;
    logic [7:0]  b, rs;
    logic        body, vdone;
    b = in_ch.data.in_byte;
    ph = ph_r; cnt = cnt_r; acc = acc_r; rs = rs_r;
    hdelta_nxt = hdelta_r; hstat_nxt = hstat_r; hmeta_nxt = hmeta_r;
    hd1_nxt = hd1_r; pl = pleft_r; cl = cleft_r; tl = tleft_r;
    hfmt_nxt = hfmt_r; htrk_nxt = htrk_r;
    if (in_ch.data.file_start) begin
      ph = smf_pkg::PH_HDR_TAG; cnt = '0; acc = '0; rs = '0;
      hdelta_nxt = '0; hstat_nxt = '0; hmeta_nxt = '0; hd1_nxt = '0;
      pl = '0; cl = '0; tl = '0; hfmt_nxt = '0; htrk_nxt = '0;
    end
    res = '0;
    res_v = 1'b0;
    body = (ph >= smf_pkg::PH_DELTA) && (ph <= smf_pkg::PH_PAYLOAD);
    cnt1 = cnt + 3'd1;
    fx = {acc[23:0], b};
    vl = {acc[24:0], b[6:0]};
    vdone = !b[7] || ({1'b0, cnt1} >= 4'(MAX_VARLEN_BYTES));
    case (ph)
      smf_pkg::PH_HDR_TAG, smf_pkg::PH_TRK_TAG: begin
        if (b != smf_pkg::tag_byte((ph == smf_pkg::PH_HDR_TAG) ? smf_pkg::TagHdr
                                   : smf_pkg::TagTrk, cnt[1:0])) begin
          res_v = 1'b1; res.kind = smf_pkg::KIND_ERROR;
          res.error_code = (ph == smf_pkg::PH_HDR_TAG) ? smf_pkg::ERR_MTHD
                           : smf_pkg::ERR_MTRK;
          ph = smf_pkg::PH_ERROR;
        end else if (cnt1 >= 3'd4) begin
          cnt = '0; acc = '0;
          ph = (ph == smf_pkg::PH_HDR_TAG) ? smf_pkg::PH_HDR_LEN : smf_pkg::PH_TRK_LEN;
        end else begin
          cnt = cnt1; acc = fx;
        end
      end
      smf_pkg::PH_HDR_LEN: begin
        cnt = cnt1; acc = fx;
        if (cnt1 >= 3'd4) begin
          if (fx != 32'd6) begin
            res_v = 1'b1; res.kind = smf_pkg::KIND_ERROR;
            res.error_code = smf_pkg::ERR_HDR_LEN; ph = smf_pkg::PH_ERROR;
          end else begin
            cnt = '0; acc = '0; ph = smf_pkg::PH_HDR_FMT;
          end
        end
      end
      smf_pkg::PH_HDR_FMT: begin
        cnt = cnt1; acc = fx;
        if (cnt1 >= 3'd2) begin
          if (fx[15:0] > 16'd2) begin
            res_v = 1'b1; res.kind = smf_pkg::KIND_ERROR;
            res.error_code = smf_pkg::ERR_FORMAT; ph = smf_pkg::PH_ERROR;
          end else begin
            hfmt_nxt = fx[1:0]; cnt = '0; acc = '0; ph = smf_pkg::PH_HDR_NTRK;
          end
        end
      end
      smf_pkg::PH_HDR_NTRK: begin
        cnt = cnt1; acc = fx;
        if (cnt1 >= 3'd2) begin
          htrk_nxt = fx[15:0]; cnt = '0; acc = '0; ph = smf_pkg::PH_HDR_DIV;
        end
      end
      smf_pkg::PH_HDR_DIV: begin
        cnt = cnt1; acc = fx;
        if (cnt1 >= 3'd2) begin
          res_v = 1'b1; res.kind = smf_pkg::KIND_HEADER;
          res.file_format = hfmt_r; res.track_count = htrk_r;
          res.division_word = fx[15:0];
          tl = htrk_r; cnt = '0; acc = '0;
          ph = (htrk_r != '0) ? smf_pkg::PH_TRK_TAG : smf_pkg::PH_DONE;
        end
      end
      smf_pkg::PH_TRK_LEN: begin
        cnt = cnt1; acc = fx;
        if (cnt1 >= 3'd4) begin
          cl = fx; res_v = 1'b1; res.kind = smf_pkg::KIND_TRACK;
          res.payload_length = fx[27:0]; rs = '0; cnt = '0; acc = '0;
          ph = smf_pkg::PH_DELTA;
          if (fx == '0) begin
            if (tl != '0) tl = tl - 16'd1;
            ph = (tl != '0) ? smf_pkg::PH_TRK_TAG : smf_pkg::PH_DONE;
          end
        end
      end
      smf_pkg::PH_DELTA: begin
        cnt = cnt1; acc = vl;
        if (vdone) begin
          hdelta_nxt = vl[27:0]; cnt = '0; acc = '0; ph = smf_pkg::PH_STATUS;
        end
      end
      smf_pkg::PH_STATUS: begin
        if (b == 8'hF0 || b == 8'hF7) begin
          hstat_nxt = b; hmeta_nxt = '0; rs = '0; cnt = '0; acc = '0;
          ph = smf_pkg::PH_VLEN;
        end else if (b == 8'hFF) begin
          hstat_nxt = b; rs = '0; ph = smf_pkg::PH_META_TYPE;
        end else if (b >= 8'hF0 || (!b[7] && rs == '0)) begin
          res_v = 1'b1; res.kind = smf_pkg::KIND_ERROR;
          res.error_code = smf_pkg::ERR_STATUS; ph = smf_pkg::PH_ERROR;
        end else if (b[7]) begin
          rs = b; hstat_nxt = b; ph = smf_pkg::PH_DATA1;
        end else begin
          hstat_nxt = rs;
          if (rs[7:4] == 4'hC || rs[7:4] == 4'hD) begin
            res_v = 1'b1; res.kind = smf_pkg::KIND_CHANNEL;
            res.delta_ticks = hdelta_r; res.status_byte = rs; res.first_data = b;
            ph = smf_pkg::PH_DELTA; cnt = '0; acc = '0;
          end else begin
            hd1_nxt = b; ph = smf_pkg::PH_DATA2;
          end
        end
      end
      smf_pkg::PH_DATA1: begin
        if (hstat_r[7:4] == 4'hC || hstat_r[7:4] == 4'hD) begin
          res_v = 1'b1; res.kind = smf_pkg::KIND_CHANNEL;
          res.delta_ticks = hdelta_r; res.status_byte = hstat_r; res.first_data = b;
          ph = smf_pkg::PH_DELTA; cnt = '0; acc = '0;
        end else begin
          hd1_nxt = b; ph = smf_pkg::PH_DATA2;
        end
      end
      smf_pkg::PH_DATA2: begin
        res_v = 1'b1; res.kind = smf_pkg::KIND_CHANNEL;
        res.delta_ticks = hdelta_r; res.status_byte = hstat_r;
        res.first_data = hd1_r; res.second_data = b;
        ph = smf_pkg::PH_DELTA; cnt = '0; acc = '0;
      end
      smf_pkg::PH_META_TYPE: begin
        hmeta_nxt = b; cnt = '0; acc = '0; ph = smf_pkg::PH_VLEN;
      end
      smf_pkg::PH_VLEN: begin
        cnt = cnt1; acc = vl;
        if (vdone) begin
          pl = vl[27:0]; res_v = 1'b1;
          res.kind = (hstat_r == 8'hFF) ? smf_pkg::KIND_META : smf_pkg::KIND_SYSEX;
          res.delta_ticks = hdelta_r; res.status_byte = hstat_r;
          res.meta_type = hmeta_r; res.payload_length = vl[27:0];
          cnt = '0; acc = '0;
          ph = (vl[27:0] != '0) ? smf_pkg::PH_PAYLOAD : smf_pkg::PH_DELTA;
        end
      end
      smf_pkg::PH_PAYLOAD: begin
        if (pl != '0) pl = pl - 28'd1;
        res_v = 1'b1; res.kind = smf_pkg::KIND_PAYLOAD;
        res.delta_ticks = hdelta_r; res.status_byte = hstat_r;
        res.meta_type = hmeta_r; res.payload_length = pl; res.first_data = b;
        if (pl == '0) begin
          cnt = '0; acc = '0; ph = smf_pkg::PH_DELTA;
        end
      end
      smf_pkg::PH_DONE: begin
        res_v = 1'b1; res.kind = smf_pkg::KIND_ERROR;
        res.error_code = smf_pkg::ERR_TRAILING; ph = smf_pkg::PH_ERROR;
      end
      default: ph = smf_pkg::PH_ERROR;
    endcase
    // chunk length bookkeeping for track body bytes
    if (body && ph != smf_pkg::PH_ERROR) begin
      if (cl != '0) cl = cl - 32'd1;
      if (cl == '0) begin
        if (tl != '0) tl = tl - 16'd1;
        ph = (tl != '0) ? smf_pkg::PH_TRK_TAG : smf_pkg::PH_DONE;
        cnt = '0; acc = '0;
      end
    end
    ph_nxt = ph; cnt_nxt = cnt; acc_nxt = acc; rs_nxt = rs;
    pleft_nxt = pl; cleft_nxt = cl; tleft_nxt = tl;
  end

  // output register
  always_comb begin
    ovalid_nxt = ovalid_r;
    if (out_ch.ready) ovalid_nxt = 1'b0;
    if (accept && res_v) ovalid_nxt = 1'b1;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= smf_pkg::PH_HDR_TAG; cnt_r <= '0; acc_r <= '0; rs_r <= '0;
      hdelta_r <= '0; hstat_r <= '0; hmeta_r <= '0; hd1_r <= '0;
      pleft_r <= '0; cleft_r <= '0; tleft_r <= '0; hfmt_r <= '0; htrk_r <= '0;
      ovalid_r <= 1'b0;
    end else begin
      ovalid_r <= ovalid_nxt;
      if (accept) begin
        ph_r <= ph_nxt; cnt_r <= cnt_nxt; acc_r <= acc_nxt; rs_r <= rs_nxt;
        hdelta_r <= hdelta_nxt; hstat_r <= hstat_nxt; hmeta_r <= hmeta_nxt;
        hd1_r <= hd1_nxt; pleft_r <= pleft_nxt; cleft_r <= cleft_nxt;
        tleft_r <= tleft_nxt; hfmt_r <= hfmt_nxt; htrk_r <= htrk_nxt;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept && res_v) odata_r <= res;
  end

  `ASSERT_IMPL(a_stall_blocks, clk, rst_n, ovalid_r && !out_ch.ready, !in_ch.ready, "input taken while result stalled")
  `ASSERT_IMPL(a_err_no_result, clk, rst_n, ph_r == smf_pkg::PH_ERROR && !in_ch.data.file_start, !res_v, "result while stuck in error")
  `ASSERT_IMPL(a_field_count, clk, rst_n, ph_r == smf_pkg::PH_DELTA || ph_r == smf_pkg::PH_VLEN, cnt_r < 3'(MAX_VARLEN_BYTES), "varlen count overrun")

endmodule
